### hdl/fce_pkg.sv
// Shared types, constants and codes of the FAT32 chain table engine.
package fce_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int WORD_W      = 32;
  localparam int CLUSTER_W   = 28;
  localparam int ACTION_W    = 3;
  localparam int STATUS_W    = 3;
  localparam int CNT_W       = 13;
  localparam int DEPTH_CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LIMIT_W     = (CNT_W > DEPTH_CNT_W) ? CNT_W : DEPTH_CNT_W;

  localparam logic [CNT_W-1:0]   ENTRY_COUNT_RESET = CNT_W'(4096);
  localparam logic [LIMIT_W-1:0] DEPTH_LIMIT       = LIMIT_W'(TABLE_DEPTH);

  // Entry word markers
  localparam logic [WORD_W-1:0] LINK_MASK = 32'h0FFF_FFFF;
  localparam logic [WORD_W-1:0] BAD_MARK  = 32'h0FFF_FFF7;
  localparam logic [WORD_W-1:0] END_MARK  = 32'h0FFF_FFFF;
  localparam logic [WORD_W-1:0] FREE_MARK = 32'h0000_0000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_FOLLOW = 3'd0,
    ACT_SET    = 3'd1,
    ACT_FINAL  = 3'd2,
    ACT_FREE   = 3'd3,
    ACT_LOAD   = 3'd4
  } fce_action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_END    = 3'd1,
    STAT_RANGE  = 3'd2,
    STAT_BAD    = 3'd3,
    STAT_TARGET = 3'd4
  } fce_status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fce_state_t;

  // Result of one item
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [CLUSTER_W-1:0] next_cluster;
  } fce_result_t;

  // Entry write request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } fce_write_t;

endpackage

### hdl/fce_entry_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module fce_entry_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/fce_action_unit.sv
// Check and modify logic: decides status, next cluster and the entry write of one item.
module fce_action_unit (
  input  logic [fce_pkg::ACTION_W-1:0]  action,
  input  logic [fce_pkg::CLUSTER_W-1:0] cluster,
  input  logic [fce_pkg::CLUSTER_W-1:0] new_link,
  input  logic [fce_pkg::WORD_W-1:0]    raw_entry,
  input  logic [fce_pkg::WORD_W-1:0]    word,
  input  logic [fce_pkg::LIMIT_W-1:0]   limit,
  output fce_pkg::fce_result_t          result,
  output fce_pkg::fce_write_t           wr
);

  logic [fce_pkg::CLUSTER_W-1:0] limit_ext;
  logic [fce_pkg::CLUSTER_W-1:0] link_val;
  logic                          cluster_oor;
  logic                          word_bad;

  assign limit_ext   = fce_pkg::CLUSTER_W'(limit);
  assign link_val    = word[fce_pkg::CLUSTER_W-1:0];
  assign cluster_oor = (cluster >= limit_ext);
  assign word_bad    = (word == fce_pkg::BAD_MARK);

  // Decide status and write for the item
  always_comb begin
    result.status       = fce_pkg::STAT_OK;
    result.next_cluster = '0;
    wr.en               = 1'b0;
    wr.addr             = cluster[fce_pkg::ADDR_W-1:0];
    wr.data             = raw_entry;
    if (action <= fce_pkg::ACT_LOAD) begin
      if (cluster_oor) begin
        result.status = fce_pkg::STAT_RANGE;
      end else begin
        unique case (action)
          fce_pkg::ACT_FOLLOW: begin
            priority if (link_val == fce_pkg::BAD_MARK[fce_pkg::CLUSTER_W-1:0]) begin
              result.status = fce_pkg::STAT_BAD;
            end else if (link_val > fce_pkg::BAD_MARK[fce_pkg::CLUSTER_W-1:0]) begin
              result.status = fce_pkg::STAT_END;
            end else if (link_val >= limit_ext) begin
              result.status = fce_pkg::STAT_TARGET;
            end else begin
              result.next_cluster = link_val;
            end
          end
          fce_pkg::ACT_SET: begin
            priority if (new_link >= limit_ext) begin
              result.status = fce_pkg::STAT_TARGET;
            end else if (word_bad) begin
              result.status = fce_pkg::STAT_BAD;
            end else begin
              wr.en   = 1'b1;
              wr.data = fce_pkg::WORD_W'(new_link);
            end
          end
          fce_pkg::ACT_FINAL: begin
            if (word_bad) begin
              result.status = fce_pkg::STAT_BAD;
            end else begin
              wr.en   = 1'b1;
              wr.data = fce_pkg::END_MARK;
            end
          end
          fce_pkg::ACT_FREE: begin
            if (word_bad) begin
              result.status = fce_pkg::STAT_BAD;
            end else begin
              wr.en   = 1'b1;
              wr.data = fce_pkg::FREE_MARK;
            end
          end
          default: begin
            wr.en   = 1'b1;
            wr.data = raw_entry;
          end
        endcase
      end
    end
  end

endmodule

### hdl/fat32_chain_table_engine.sv
// Top level of the FAT32 chain table engine: sequencer, config register and table RAM.
//
// Use: drive action, cluster, new_link and raw_entry and raise start; the item
// is taken at the clock edge where start is high and busy is low. At that edge
// the table RAM reads the entry of the cluster. In the next cycle (busy high)
// the entry is checked, the write-back is made and the result is registered.
// The result is on status and next_cluster for exactly one cycle while done is
// high; done and the result are registered from the execute cycle. The receiver
// cannot stall; results must be taken when done is high.
// The table RAM has registered read data, so the entry is read before the
// read-modify-write cycle and no new item is taken while busy. busy is low again
// while the result is shown, so the next item may be taken in that cycle; its
// read sees the previous write.
// Config: entry_count is written through cfg_valid/cfg_ready/cfg_data, ready
// always high; write it only while idle.
// Reset (rst, synchronous): sequencer idle, no result pending, entry_count 4096.
// Table contents are undefined until written; load them with the load action.
module fat32_chain_table_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [fce_pkg::ACTION_W-1:0]  action,
  input  logic [fce_pkg::CLUSTER_W-1:0] cluster,
  input  logic [fce_pkg::CLUSTER_W-1:0] new_link,
  input  logic [fce_pkg::WORD_W-1:0]    raw_entry,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fce_pkg::CNT_W-1:0]     cfg_data,
  output logic                          done,
  output logic [fce_pkg::STATUS_W-1:0]  status,
  output logic [fce_pkg::CLUSTER_W-1:0] next_cluster
);

  fce_pkg::fce_state_t state, state_next;

  logic [fce_pkg::CNT_W-1:0]     entry_count;
  logic [fce_pkg::LIMIT_W-1:0]   limit;
  logic [fce_pkg::ACTION_W-1:0]  item_action;
  logic [fce_pkg::CLUSTER_W-1:0] item_cluster;
  logic [fce_pkg::CLUSTER_W-1:0] item_link;
  logic [fce_pkg::WORD_W-1:0]    item_raw;
  logic [fce_pkg::WORD_W-1:0]    rd_word;
  logic                          accept;
  logic                          exec;
  fce_pkg::fce_result_t          result;
  fce_pkg::fce_write_t           wr;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Clamp the entry count to the table depth
  always_comb begin
    if (fce_pkg::LIMIT_W'(entry_count) < fce_pkg::DEPTH_LIMIT) begin
      limit = fce_pkg::LIMIT_W'(entry_count);
    end else begin
      limit = fce_pkg::DEPTH_LIMIT;
    end
  end

  // Hold the config register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= fce_pkg::ENTRY_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fce_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      fce_pkg::FSM_IDLE: begin
        if (start) begin
          state_next = fce_pkg::FSM_EXEC;
        end
      end
      fce_pkg::FSM_EXEC: begin
        state_next = fce_pkg::FSM_IDLE;
      end
      default: begin
        state_next = fce_pkg::FSM_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    unique case (state)
      fce_pkg::FSM_IDLE: begin
        busy = 1'b0;
      end
      fce_pkg::FSM_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Capture the item fields
  always_ff @(posedge clk) begin
    if (accept) begin
      item_action  <= action;
      item_cluster <= cluster;
      item_link    <= new_link;
      item_raw     <= raw_entry;
    end
  end

  fce_entry_ram #(
    .DEPTH(fce_pkg::TABLE_DEPTH),
    .WIDTH(fce_pkg::WORD_W),
    .AW   (fce_pkg::ADDR_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr.en && exec),
    .wr_addr(wr.addr),
    .wr_data(wr.data),
    .rd_en  (accept),
    .rd_addr(cluster[fce_pkg::ADDR_W-1:0]),
    .rd_data(rd_word)
  );

  fce_action_unit u_action (
    .action   (item_action),
    .cluster  (item_cluster),
    .new_link (item_link),
    .raw_entry(item_raw),
    .word     (rd_word),
    .limit    (limit),
    .result   (result),
    .wr       (wr)
  );

  // Strobe the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= exec;
    end
  end

  // Register the result payload
  always_ff @(posedge clk) begin
    if (exec) begin
      status       <= result.status;
      next_cluster <= result.next_cluster;
    end
  end

  // An accepted item is worked on in the next cycle
  assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("accepted item did not enter the execute cycle");

  // busy drops again after the execute cycle
  assert property (@(posedge clk) disable iff (rst) busy |=> !busy)
    else $error("execute cycle longer than one cycle");

  // Each result follows an execute cycle
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without an executed item");

  // A nonzero next cluster comes only with status ok
  assert property (@(posedge clk) disable iff (rst)
    (done && (next_cluster != '0)) |-> (status == fce_pkg::STAT_OK))
    else $error("next cluster given with an error status");

  // A write-back never targets a cluster at or beyond the active limit
  assert property (@(posedge clk) disable iff (rst)
    (exec && wr.en) |-> (item_cluster < fce_pkg::CLUSTER_W'(limit)))
    else $error("entry write outside the active range");

endmodule
